>>> rtl/core/sltm_pkg.sv
`timescale 1ns / 1ps

package sltm_pkg;

  localparam int PIX_W    = 7;
  localparam int MAP_ROWS = 16;
  localparam int MAP_COLS = 16;
  localparam int ROW_W    = 4;
  localparam int STEP_W   = 8;
  localparam int DIFF_W   = 17;
  localparam int KIND_W   = 2;

  localparam int TILE_PIXELS_DEF   = 8;
  localparam int SCREEN_PIXELS_DEF = 128;

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR = 2'd0,
    KIND_LINE  = 2'd1,
    KIND_READ  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic start;   // item accepted this cycle
    logic step;    // advance the walk by one pixel
    logic finish;  // move result into the output register
  } cmd_t;

  typedef struct packed {
    logic walk_done;
  } status_t;

  // one-hot tile index of a pixel coordinate, zero when past the last tile
  function automatic logic [MAP_COLS-1:0] tile_hot(input logic [PIX_W-1:0] p,
                                                   input int unsigned tile_px);
    logic [MAP_COLS-1:0] hot;
    int unsigned lo;
    hot = '0;
    for (int c = 0; c < MAP_COLS; c++) begin
      lo = c * tile_px;
      hot[c] = (32'(p) >= lo) && (32'(p) < lo + tile_px);
    end
    return hot;
  endfunction

endpackage

>>> rtl/core/supercover_line_tile_marker_core.sv
`timescale 1ns / 1ps

// Dirty-tile bitmap over a square screen of SCREEN_PIXELS pixels cut into
// TILE_PIXELS tiles (16 x 16 tile bits). An item either clears the bitmap,
// marks every tile touched by the supercover line between two pixels, or
// reads one tile row; each item gives exactly one result. The block works on
// one item at a time. A clear, read or unused kind goes from acceptance
// straight to the done state; a line first passes through the walk state.
// In the done state the result is loaded into the output register once that
// register is free or being emptied. The line walker advances one pixel
// per cycle, and a line on a 128-pixel screen takes at most 253 steps. The
// next item is accepted in the cycle after a result enters the output
// register, even if that result has not been taken yet.
module supercover_line_tile_marker_core #(
  parameter int TILE_PIXELS   = sltm_pkg::TILE_PIXELS_DEF,
  parameter int SCREEN_PIXELS = sltm_pkg::SCREEN_PIXELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sltm_pkg::KIND_W-1:0]   kind,
  input  logic [sltm_pkg::PIX_W-1:0]    start_x,
  input  logic [sltm_pkg::PIX_W-1:0]    start_y,
  input  logic [sltm_pkg::PIX_W-1:0]    end_x,
  input  logic [sltm_pkg::PIX_W-1:0]    end_y,
  input  logic [sltm_pkg::ROW_W-1:0]    row_select,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sltm_pkg::MAP_COLS-1:0] row_bits,
  output logic [sltm_pkg::STEP_W-1:0]   steps_taken
);
  import sltm_pkg::*;

  cmd_t    cmd;
  status_t status;

  sltm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  sltm_dp #(
    .TILE_PIXELS   (TILE_PIXELS),
    .SCREEN_PIXELS (SCREEN_PIXELS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .kind        (kind),
    .start_x     (start_x),
    .start_y     (start_y),
    .end_x       (end_x),
    .end_y       (end_y),
    .row_select  (row_select),
    .row_bits    (row_bits),
    .steps_taken (steps_taken)
  );

  // one item in flight: nothing new is taken right after an acceptance
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("item accepted while previous item in flight");

  // a line walk never exceeds the screen span
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (steps_taken <= STEP_W'(254)))
    else $error("step count out of range");

  // a result carries either row bits or a step count, never both
  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (row_bits == '0 || steps_taken == '0))
    else $error("result mixes read bits and step count");

  // walking only happens with no item being taken and no result being loaded
  a_walk_excl: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> !in_ready && !cmd.finish)
    else $error("walk step overlaps acceptance or result load");

endmodule

>>> rtl/core/sltm_ctrl.sv
`timescale 1ns / 1ps

module sltm_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [sltm_pkg::KIND_W-1:0] kind,
  output logic                        out_valid,
  input  logic                        out_ready,
  output sltm_pkg::cmd_t              cmd,
  input  sltm_pkg::status_t           status
);
  import sltm_pkg::*;

  state_t state, state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = (kind_t'(kind) == KIND_LINE) ? ST_WALK : ST_DONE;
        end
      end
      ST_WALK: begin
        if (status.walk_done) begin
          state_next = ST_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_DONE: begin
        // output register is free or being emptied this cycle
        if (!out_valid || out_ready) begin
          cmd.finish     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

>>> rtl/core/sltm_dp.sv
`timescale 1ns / 1ps

module sltm_dp #(
  parameter int TILE_PIXELS   = sltm_pkg::TILE_PIXELS_DEF,
  parameter int SCREEN_PIXELS = sltm_pkg::SCREEN_PIXELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  sltm_pkg::cmd_t               cmd,
  output sltm_pkg::status_t            status,
  input  logic [sltm_pkg::KIND_W-1:0]  kind,
  input  logic [sltm_pkg::PIX_W-1:0]   start_x,
  input  logic [sltm_pkg::PIX_W-1:0]   start_y,
  input  logic [sltm_pkg::PIX_W-1:0]   end_x,
  input  logic [sltm_pkg::PIX_W-1:0]   end_y,
  input  logic [sltm_pkg::ROW_W-1:0]   row_select,
  output logic [sltm_pkg::MAP_COLS-1:0] row_bits,
  output logic [sltm_pkg::STEP_W-1:0]  steps_taken
);
  import sltm_pkg::*;

  logic [MAP_COLS-1:0] dirty [MAP_ROWS];

  logic [PIX_W-1:0]         px, py, nx, ny, ix, iy;
  logic                     sx_neg, sy_neg;
  logic signed [DIFF_W-1:0] d;
  logic [STEP_W-1:0]        steps;
  logic [MAP_COLS-1:0]      res_bits;

  logic [PIX_W-1:0]         px_next, py_next, nx_in, ny_in;
  logic                     move_x, move_y;
  logic signed [DIFF_W-1:0] d_next, two_nx, two_ny;
  logic [PIX_W-1:0]         mark_x, mark_y;
  logic                     mark_en, on_screen;
  logic [MAP_COLS-1:0]      col_hot;
  logic [MAP_ROWS-1:0]      row_hot;
  kind_t                    kind_in;

  assign kind_in = kind_t'(kind);
  assign nx_in   = (end_x >= start_x) ? end_x - start_x : start_x - end_x;
  assign ny_in   = (end_y >= start_y) ? end_y - start_y : start_y - end_y;

  assign status.walk_done = (ix == nx) && (iy == ny);

  // d tracks (1+2ix)*ny - (1+2iy)*nx
  assign two_nx = DIFF_W'({nx, 1'b0});
  assign two_ny = DIFF_W'({ny, 1'b0});
  assign move_x = (d <= 0);
  assign move_y = (d >= 0);

  always_comb begin
    px_next = px;
    py_next = py;
    d_next  = d;
    if (move_x) begin
      px_next = sx_neg ? px - PIX_W'(1) : px + PIX_W'(1);
      d_next  = d_next + two_ny;
    end
    if (move_y) begin
      py_next = sy_neg ? py - PIX_W'(1) : py + PIX_W'(1);
      d_next  = d_next - two_nx;
    end
  end

  // start pixel is marked when the item is taken, later pixels as they are reached
  assign mark_x    = cmd.start ? start_x : px_next;
  assign mark_y    = cmd.start ? start_y : py_next;
  assign mark_en   = (cmd.start && kind_in == KIND_LINE) || cmd.step;
  assign on_screen = (32'(mark_x) < 32'(SCREEN_PIXELS)) && (32'(mark_y) < 32'(SCREEN_PIXELS));
  assign col_hot   = tile_hot(mark_x, TILE_PIXELS);
  assign row_hot   = tile_hot(mark_y, TILE_PIXELS);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < MAP_ROWS; r++) begin
        dirty[r] <= '0;
      end
    end else if (cmd.start && kind_in == KIND_CLEAR) begin
      for (int r = 0; r < MAP_ROWS; r++) begin
        dirty[r] <= '0;
      end
    end else if (mark_en && on_screen) begin
      for (int r = 0; r < MAP_ROWS; r++) begin
        if (row_hot[r]) begin
          dirty[r] <= dirty[r] | col_hot;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      px       <= start_x;
      py       <= start_y;
      nx       <= (kind_in == KIND_LINE) ? nx_in : '0;
      ny       <= (kind_in == KIND_LINE) ? ny_in : '0;
      sx_neg   <= !(end_x > start_x);
      sy_neg   <= !(end_y > start_y);
      ix       <= '0;
      iy       <= '0;
      d        <= DIFF_W'(ny_in) - DIFF_W'(nx_in);
      steps    <= '0;
      res_bits <= (kind_in == KIND_READ) ? dirty[row_select] : '0;
    end else if (cmd.step) begin
      px    <= px_next;
      py    <= py_next;
      d     <= d_next;
      steps <= steps + STEP_W'(1);
      if (move_x) begin
        ix <= ix + PIX_W'(1);
      end
      if (move_y) begin
        iy <= iy + PIX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      row_bits    <= res_bits;
      steps_taken <= steps;
    end
  end

endmodule
